[sv/vn3d_pkg.sv]
// vn3d_pkg.sv: shared constants of the 3-d vector normalizer
`timescale 1ns / 1ps
package vn3d_pkg;
  localparam int unsigned COMP_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 14;
  localparam int unsigned LANES          = 3;
endpackage

[sv/vn3d_if.sv]
// vn3d_if.sv: valid/ready channel interfaces for vectors and unit vectors
`timescale 1ns / 1ps
interface vn3d_vec_if import vn3d_pkg::*; #(
  parameter int unsigned COMP_WIDTH = COMP_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] comp_x;
  logic signed [COMP_WIDTH-1:0] comp_y;
  logic signed [COMP_WIDTH-1:0] comp_z;
  modport source (output valid, comp_x, comp_y, comp_z, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface vn3d_unit_if import vn3d_pkg::*; #(
  parameter int unsigned COMP_WIDTH = COMP_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] unit_x;
  logic signed [COMP_WIDTH-1:0] unit_y;
  logic signed [COMP_WIDTH-1:0] unit_z;
  logic                         zero_vector;
  modport source (output valid, unit_x, unit_y, unit_z, zero_vector, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, zero_vector, output ready);
endinterface

[sv/vector_normalize_3d_core.sv]
// vector_normalize_3d_core.sv: top level of the pipelined 3-d vector normalizer
//
// vec_i takes one vector (comp_x, comp_y, comp_z) per transaction; unit_o
// returns one unit vector in signed Q1.FRAC_BITS with a zero_vector flag.
// A zero vector comes back unchanged with zero_vector set.
// Every component is rounded to nearest, ties away from zero, exactly.
// Throughput: one vector per cycle while the receiver does not stall.
// From an accepted transaction to the result on unit_o the pipe has
// four setup stages, one stage per quotient bit of the search and one
// output register.
// All stages share one advance enable; when the receiver stalls with a
// result waiting, the whole pipe holds and vec_i.ready drops, so nothing
// is lost or repeated. Bubbles inside the pipe do not close up.
// Reset clears all valid bits; no result is pending after reset.
`timescale 1ns / 1ps
module vector_normalize_3d_core import vn3d_pkg::*; #(
  parameter int unsigned COMP_WIDTH = COMP_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vn3d_vec_if.sink    vec_i,
  vn3d_unit_if.source unit_o
);
  localparam int unsigned CW = COMP_WIDTH;
  localparam int unsigned MW = 2 * COMP_WIDTH;
  localparam int unsigned RW = 2 * COMP_WIDTH + 2 * FRAC_BITS + 3;
  localparam int unsigned QB = FRAC_BITS + 1;
  localparam int unsigned XW = ((QB > CW) ? QB : CW) + 1;
  localparam int unsigned NS = FRAC_BITS + 2;

  logic en;
  logic [NS-1:0]                      vld_s;
  logic [NS-1:0][LANES-1:0][CW-1:0]   raw_s;
  logic [NS-1:0][LANES-1:0]           neg_s;
  logic [NS-1:0][MW-1:0]              msq_s;
  logic [NS-1:0]                      zero_s;
  logic [NS-1:0][LANES-1:0][RW-1:0]   res_s, um_s;
  logic [NS-1:0][LANES-1:0][QB-1:0]   quo_s;

  logic                     out_vld_q;
  logic                     out_zero_q;
  logic [LANES-1:0][CW-1:0] out_q, out_d;
  logic [LANES-1:0][XW-1:0] qx;

  assign en          = !out_vld_q || unit_o.ready;
  assign vec_i.ready = en;

  vn3d_front #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vec_i.valid),
    .raw_i   ({vec_i.comp_z, vec_i.comp_y, vec_i.comp_x}),
    .valid_o (vld_s[0]),
    .raw_o   (raw_s[0]),
    .neg_o   (neg_s[0]),
    .msq_o   (msq_s[0]),
    .zero_o  (zero_s[0]),
    .res_o   (res_s[0])
  );
  assign um_s[0]  = '0;
  assign quo_s[0] = '0;

  for (genvar j = 1; j < NS; j++) begin : g_step
    vn3d_qstep #(
      .COMP_WIDTH (COMP_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .BIT_POS    (FRAC_BITS + 1 - j)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld_s[j-1]),
      .raw_i   (raw_s[j-1]),
      .neg_i   (neg_s[j-1]),
      .msq_i   (msq_s[j-1]),
      .zero_i  (zero_s[j-1]),
      .res_i   (res_s[j-1]),
      .um_i    (um_s[j-1]),
      .quo_i   (quo_s[j-1]),
      .valid_o (vld_s[j]),
      .raw_o   (raw_s[j]),
      .neg_o   (neg_s[j]),
      .msq_o   (msq_s[j]),
      .zero_o  (zero_s[j]),
      .res_o   (res_s[j]),
      .um_o    (um_s[j]),
      .quo_o   (quo_s[j])
    );
  end

  // apply sign and clamp to the signed field; a zero vector passes through raw
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      qx[i] = XW'(quo_s[NS-1][i]);
      if (zero_s[NS-1]) begin
        out_d[i] = raw_s[NS-1][i];
      end else if (neg_s[NS-1][i]) begin
        if (qx[i] > (XW'(1) << (CW - 1))) begin
          qx[i] = XW'(1) << (CW - 1);
        end
        out_d[i] = CW'(~qx[i] + 1'b1);
      end else begin
        if (qx[i] > ((XW'(1) << (CW - 1)) - 1'b1)) begin
          qx[i] = (XW'(1) << (CW - 1)) - 1'b1;
        end
        out_d[i] = CW'(qx[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_s[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q      <= out_d;
      out_zero_q <= zero_s[NS-1];
    end
  end

  assign unit_o.valid       = out_vld_q;
  assign unit_o.unit_x      = out_q[0];
  assign unit_o.unit_y      = out_q[1];
  assign unit_o.unit_z      = out_q[2];
  assign unit_o.zero_vector = out_zero_q;
endmodule

[sv/vn3d_front.sv]
// vn3d_front.sv: magnitudes, squares, squared norm and search setup (four stages)
`timescale 1ns / 1ps
module vn3d_front import vn3d_pkg::*; #(
  parameter int unsigned COMP_WIDTH = COMP_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  localparam int unsigned CW = COMP_WIDTH,
  localparam int unsigned MW = 2 * COMP_WIDTH,
  localparam int unsigned RW = 2 * COMP_WIDTH + 2 * FRAC_BITS + 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [LANES-1:0][CW-1:0]  raw_i,
  output logic                      valid_o,
  output logic [LANES-1:0][CW-1:0]  raw_o,
  output logic [LANES-1:0]          neg_o,
  output logic [MW-1:0]             msq_o,
  output logic                      zero_o,
  output logic [LANES-1:0][RW-1:0]  res_o
);
  logic [3:0]               vld_q;
  logic [LANES-1:0][CW-1:0] raw1_q, raw2_q, raw3_q, raw4_q;
  logic [LANES-1:0]         neg1_q, neg2_q, neg3_q, neg4_q;
  logic [LANES-1:0][CW-1:0] mag1_q;
  logic [LANES-1:0][MW-1:0] sq2_q, sq3_q;
  logic [MW-1:0]            msq3_q, msq4_q;
  logic                     zero4_q;
  logic [LANES-1:0][RW-1:0] res4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < LANES; i++) begin
        raw1_q[i] <= raw_i[i];
        neg1_q[i] <= raw_i[i][CW-1];
        mag1_q[i] <= raw_i[i][CW-1] ? (~raw_i[i] + 1'b1) : raw_i[i];
        sq2_q[i]  <= MW'(mag1_q[i]) * MW'(mag1_q[i]);
        // right side of the search test: a^2 * 4^(frac+1) minus the squared norm
        res4_q[i] <= (RW'(sq3_q[i]) << (2 * FRAC_BITS + 2)) - RW'(msq3_q);
      end
      raw2_q  <= raw1_q;
      neg2_q  <= neg1_q;
      raw3_q  <= raw2_q;
      neg3_q  <= neg2_q;
      sq3_q   <= sq2_q;
      msq3_q  <= sq2_q[0] + sq2_q[1] + sq2_q[2];
      raw4_q  <= raw3_q;
      neg4_q  <= neg3_q;
      msq4_q  <= msq3_q;
      zero4_q <= (msq3_q == '0);
    end
  end

  assign valid_o = vld_q[3];
  assign raw_o   = raw4_q;
  assign neg_o   = neg4_q;
  assign msq_o   = msq4_q;
  assign zero_o  = zero4_q;
  assign res_o   = res4_q;
endmodule

[sv/vn3d_qstep.sv]
// vn3d_qstep.sv: one quotient bit of the exact rounded c/sqrt(m) search
`timescale 1ns / 1ps
module vn3d_qstep import vn3d_pkg::*; #(
  parameter int unsigned COMP_WIDTH = COMP_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned BIT_POS    = FRAC_BITS_DEF,
  localparam int unsigned CW = COMP_WIDTH,
  localparam int unsigned MW = 2 * COMP_WIDTH,
  localparam int unsigned RW = 2 * COMP_WIDTH + 2 * FRAC_BITS + 3,
  localparam int unsigned QB = FRAC_BITS + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [LANES-1:0][CW-1:0]  raw_i,
  input  logic [LANES-1:0]          neg_i,
  input  logic [MW-1:0]             msq_i,
  input  logic                      zero_i,
  input  logic [LANES-1:0][RW-1:0]  res_i,
  input  logic [LANES-1:0][RW-1:0]  um_i,
  input  logic [LANES-1:0][QB-1:0]  quo_i,
  output logic                      valid_o,
  output logic [LANES-1:0][CW-1:0]  raw_o,
  output logic [LANES-1:0]          neg_o,
  output logic [MW-1:0]             msq_o,
  output logic                      zero_o,
  output logic [LANES-1:0][RW-1:0]  res_o,
  output logic [LANES-1:0][RW-1:0]  um_o,
  output logic [LANES-1:0][QB-1:0]  quo_o
);
  logic                     vld_q;
  logic [LANES-1:0][CW-1:0] raw_q;
  logic [LANES-1:0]         neg_q;
  logic [MW-1:0]            msq_q;
  logic                     zero_q;
  logic [LANES-1:0][RW-1:0] res_q, res_d, um_q, um_d;
  logic [LANES-1:0][QB-1:0] quo_q, quo_d;
  logic [LANES-1:0][RW-1:0] cand;

  // residual r = a^2*4^(f+1) - (u-1)^2*m, u = 2q; um = u*m
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      cand[i] = res_i[i] - (um_i[i] << (BIT_POS + 2))
              - (RW'(msq_i) << (2 * BIT_POS + 2)) + (RW'(msq_i) << (BIT_POS + 2));
      if (!quo_i[i][QB-1] && !cand[i][RW-1]) begin
        res_d[i] = cand[i];
        um_d[i]  = um_i[i] + (RW'(msq_i) << (BIT_POS + 1));
        quo_d[i] = quo_i[i] | (QB'(1) << BIT_POS);
      end else begin
        res_d[i] = res_i[i];
        um_d[i]  = um_i[i];
        quo_d[i] = quo_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_q  <= raw_i;
      neg_q  <= neg_i;
      msq_q  <= msq_i;
      zero_q <= zero_i;
      res_q  <= res_d;
      um_q   <= um_d;
      quo_q  <= quo_d;
    end
  end

  assign valid_o = vld_q;
  assign raw_o   = raw_q;
  assign neg_o   = neg_q;
  assign msq_o   = msq_q;
  assign zero_o  = zero_q;
  assign res_o   = res_q;
  assign um_o    = um_q;
  assign quo_o   = quo_q;
endmodule

[test/testbench.sv]
// testbench.sv: self-checking testbench for the 3-d vector normalizer
`timescale 1ns / 1ps
module testbench;
  import vn3d_pkg::*;

  localparam int unsigned CW = COMP_WIDTH_DEF;
  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam int N_RANDOM = 1030;
  localparam int LATENCY = FB + 6;

  typedef logic signed [CW-1:0] comp_t;
  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_t;
  typedef struct packed {
    comp_t ux;
    comp_t uy;
    comp_t uz;
    logic  zero;
  } unit_t;
  // directed row: known marks a hand-typed result
  typedef struct {
    vec_t  v;
    bit    known;
    unit_t res;
  } row_t;

  logic clk_i;
  logic rst_ni;

  vn3d_vec_if  #(.COMP_WIDTH(CW)) vec_ch ();
  vn3d_unit_if #(.COMP_WIDTH(CW)) unit_ch ();

  vector_normalize_3d_core #(.COMP_WIDTH(CW), .FRAC_BITS(FB)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vec_i (vec_ch.sink),
    .unit_o(unit_ch.source)
  );

  unit_t expected_units[$];
  int    mismatches;
  int    accepted;
  bit    stim_done;
  bit    no_idle;
  row_t  rows[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  // largest q in [0, 2^FB] with (2q-1)^2 * msq <= a^2 * 4^(FB+1)
  function automatic longint unsigned unit_quotient(longint unsigned a,
                                                    longint unsigned msq);
    logic [127:0]    lim;
    logic [127:0]    lhs;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned t;
    lim = 128'(a * a) << (2 * FB + 2);
    lo = 0;
    hi = 64'd1 << FB;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      t = 2 * mid - 1;
      lhs = 128'(t * t) * 128'(msq);
      if (lhs <= lim) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic unit_t normalize(vec_t v);
    unit_t           r;
    comp_t           c[3];
    longint unsigned m[3];
    longint unsigned msq;
    longint unsigned q;
    comp_t           o[3];
    c[0] = v.x;
    c[1] = v.y;
    c[2] = v.z;
    msq = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? longint'(-longint'(c[i])) : longint'(c[i]);
      msq += m[i] * m[i];
    end
    if (msq == 0) begin
      r = '{ux: v.x, uy: v.y, uz: v.z, zero: 1'b1};
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      q = unit_quotient(m[i], msq);
      if (c[i] < 0) begin
        if (q > (64'd1 << (CW - 1))) q = 64'd1 << (CW - 1);
        o[i] = comp_t'(-longint'(q));
      end else begin
        if (q > (64'd1 << (CW - 1)) - 1) q = (64'd1 << (CW - 1)) - 1;
        o[i] = comp_t'(q);
      end
    end
    r = '{ux: o[0], uy: o[1], uz: o[2], zero: 1'b0};
    return r;
  endfunction

  function automatic vec_t mk(int x, int y, int z);
    vec_t v;
    v = '{x: comp_t'(x), y: comp_t'(y), z: comp_t'(z)};
    return v;
  endfunction

  function automatic unit_t mu(int x, int y, int z, bit zero);
    unit_t u;
    u = '{ux: comp_t'(x), uy: comp_t'(y), uz: comp_t'(z), zero: zero};
    return u;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return comp_t'($urandom_range(0, 1) ? -32768 : 32767);
      1: return comp_t'($signed($urandom_range(0, 6)) - 3);
      2: return comp_t'($signed($urandom_range(0, 200)) - 100);
      default: return comp_t'($urandom);
    endcase
  endfunction

  task automatic send(vec_t v);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      vec_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    vec_ch.valid  <= 1'b1;
    vec_ch.comp_x <= v.x;
    vec_ch.comp_y <= v.y;
    vec_ch.comp_z <= v.z;
    do @(posedge clk_i); while (!vec_ch.ready);
  endtask

  // stalls on the result side
  initial begin
    unit_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        unit_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      unit_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  // predictions are queued at the accepting edge, then compared here
  always @(posedge clk_i) begin
    if (rst_ni && vec_ch.valid && vec_ch.ready) begin
      expected_units.push_back(normalize(mk(vec_ch.comp_x, vec_ch.comp_y,
                                            vec_ch.comp_z)));
      accepted++;
    end
    if (rst_ni && unit_ch.valid && unit_ch.ready) begin
      if (expected_units.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
      end else begin
        unit_t want;
        unit_t got;
        want = expected_units.pop_front();
        got = mu(unit_ch.unit_x, unit_ch.unit_y, unit_ch.unit_z, unit_ch.zero_vector);
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d z%0b, got %0d %0d %0d z%0b",
                     want.ux, want.uy, want.uz, want.zero,
                     got.ux, got.uy, got.uz, got.zero);
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    vec_ch.valid = 1'b0;
    vec_ch.comp_x = '0;
    vec_ch.comp_y = '0;
    vec_ch.comp_z = '0;
    mismatches = 0;
    accepted = 0;
    no_idle = 1'b0;
    // zero vector, single-axis vectors and (3, 4, 0) are typed in; the rest use the predictor
    rows.push_back('{mk(0, 0, 0), 1, mu(0, 0, 0, 1)});
    rows.push_back('{mk(1, 0, 0), 1, mu(16384, 0, 0, 0)});
    rows.push_back('{mk(0, -1, 0), 1, mu(0, -16384, 0, 0)});
    rows.push_back('{mk(0, 0, 32767), 1, mu(0, 0, 16384, 0)});
    rows.push_back('{mk(-32768, 0, 0), 1, mu(-16384, 0, 0, 0)});
    rows.push_back('{mk(0, 0, -32768), 1, mu(0, 0, -16384, 0)});
    rows.push_back('{mk(3, 4, 0), 1, mu(9830, 13107, 0, 0)});
    rows.push_back('{mk(-32768, -32768, -32768), 0, '0});
    rows.push_back('{mk(32767, 32767, 32767), 0, '0});
    rows.push_back('{mk(32767, -32768, 0), 0, '0});
    rows.push_back('{mk(1, 1, 1), 0, '0});
    rows.push_back('{mk(-1, 1, -1), 0, '0});
    rows.push_back('{mk(1, 32767, 0), 0, '0});
    rows.push_back('{mk(-1, -32768, 1), 0, '0});
    rows.push_back('{mk(2, 3, 6), 0, '0});
    rows.push_back('{mk(1, 1, 0), 0, '0});
    rows.push_back('{mk(-21846, 21845, 12345), 0, '0});
    rows.push_back('{mk(0, 0, 1), 0, '0});
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      if (rows[i].known && normalize(rows[i].v) !== rows[i].res) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d disagrees with predictor", i);
      end
      send(rows[i].v);
    end
    vec_ch.valid <= 1'b0;
    // drain the pipe before the random part
    while (expected_units.size() != 0) @(posedge clk_i);
    for (int n = 0; n < N_RANDOM; n++) begin
      vec_t v;
      if (n > N_RANDOM - 150) no_idle = 1'b1;
      v = '{x: rand_comp(), y: rand_comp(), z: rand_comp()};
      if ($urandom_range(0, 5) == 0) v.z = '0;
      if ($urandom_range(0, 40) == 0) v = '0;
      send(v);
    end
    vec_ch.valid <= 1'b0;
    fork
      begin
        while (expected_units.size() != 0) @(posedge clk_i);
        repeat (LATENCY + 10) @(posedge clk_i);
      end
      begin
        repeat (200_000) @(posedge clk_i);
      end
    join_any
    if (mismatches == 0 && expected_units.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[vector_normalize_3d_core.f]
sv/vn3d_pkg.sv
sv/vn3d_if.sv
sv/vn3d_front.sv
sv/vn3d_qstep.sv
sv/vector_normalize_3d_core.sv
test/testbench.sv
